// File: src/ksc_pkg.sv
// ----------------------------------------------------------------------------
// ksc_pkg
// Shared constants, types and helpers of the key sensor conditioner.
// ----------------------------------------------------------------------------
package ksc_pkg;

  localparam int NUM_KEYS   = 25;
  localparam int KEY_W      = 5;
  localparam int ADDR_W     = $clog2(NUM_KEYS);
  localparam int SAMPLE_W   = 10;
  localparam int SAMPLE_MAX = 1023;
  localparam int BOUND_W    = 12;
  localparam int WIDE_W     = BOUND_W + 2;
  localparam int TIME_W     = 32;
  localparam int LEVEL_W    = 16;
  localparam int DEB_W      = 16;
  localparam int CAL_MARGIN = 10;
  localparam int REM_W      = BOUND_W;
  localparam int DIV_CNT_W  = $clog2(LEVEL_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam logic [LEVEL_W-1:0] PRESS_TH_RESET   = LEVEL_W'(39322);
  localparam logic [LEVEL_W-1:0] RELEASE_TH_RESET = LEVEL_W'(26214);

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_PREP,
    ST_DIV,
    ST_DECIDE
  } state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CALIBRATE  = 3'd0,
    CFG_INVERT     = 3'd1,
    CFG_PRESS_TH   = 3'd2,
    CFG_RELEASE_TH = 3'd3,
    CFG_DEBOUNCE   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [BOUND_W-1:0] lower;
    logic signed [BOUND_W-1:0] upper;
    logic [TIME_W-1:0]         last_time;
    logic [SAMPLE_W-1:0]       prev;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_RESET = '{
    lower:     '0,
    upper:     BOUND_W'(SAMPLE_MAX),
    last_time: '0,
    prev:      '0
  };

  localparam logic signed [WIDE_W-1:0] BOUND_TOP = WIDE_W'(2 ** (BOUND_W - 1) - 1);
  localparam logic signed [WIDE_W-1:0] BOUND_BOT = WIDE_W'(-(2 ** (BOUND_W - 1)));

  function automatic logic signed [BOUND_W-1:0] sat_bound(input logic signed [WIDE_W-1:0] v);
    logic signed [BOUND_W-1:0] r;
    if (v > BOUND_TOP) begin
      r = BOUND_TOP[BOUND_W-1:0];
    end else if (v < BOUND_BOT) begin
      r = BOUND_BOT[BOUND_W-1:0];
    end else begin
      r = v[BOUND_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: src/ksc_ram.sv
// ----------------------------------------------------------------------------
// ksc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ksc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/key_sensor_conditioner_top.sv
// ----------------------------------------------------------------------------
// key_sensor_conditioner_top
// Per-key calibration, normalization and hysteresis press detection.
// ----------------------------------------------------------------------------
// sequence: a sample item goes through CALC, PREP, DIV and DECIDE, skipping
//   DIV when the level is zero or saturated; a load item or unknown key goes
//   from CALC to DECIDE, which waits while out_stall holds the last result
// divider: radix-2, one level bit per cycle; items are handled one at a time
// reset: registers to defaults; per-key valid bits make every entry of the
//   key memory read as its default bounds, so there is no clearing pass
module key_sensor_conditioner_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ksc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ksc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                func,
  input  logic [ksc_pkg::KEY_W-1:0]           key_index,
  input  logic [ksc_pkg::SAMPLE_W-1:0]        sample,
  input  logic [ksc_pkg::TIME_W-1:0]          time_ms,
  input  logic signed [ksc_pkg::BOUND_W-1:0]  bound_low,
  input  logic signed [ksc_pkg::BOUND_W-1:0]  bound_high,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ksc_pkg::KEY_W-1:0]           out_key,
  output logic [ksc_pkg::LEVEL_W-1:0]         level,
  output logic                                pressed,
  output logic                                press_changed,
  output logic                                raw_changed,
  output logic [ksc_pkg::NUM_KEYS-1:0]        press_bitmap
);

  import ksc_pkg::*;

  // configuration
  logic [NUM_KEYS-1:0] calibrate_mask;
  logic [NUM_KEYS-1:0] invert_mask;
  logic [LEVEL_W-1:0]  press_threshold;
  logic [LEVEL_W-1:0]  release_threshold;
  logic [DEB_W-1:0]    debounce_ms;

  // control
  state_t              state;
  state_t              state_next;
  logic [NUM_KEYS-1:0] key_valid;
  logic [NUM_KEYS-1:0] pressed_bits;
  logic [NUM_KEYS-1:0] pressed_bits_next;
  logic [NUM_KEYS-1:0] reported_bits;
  logic [NUM_KEYS-1:0] reported_bits_next;
  logic [DIV_CNT_W-1:0] div_cnt;

  // captured item
  logic                      func_q;
  logic [KEY_W-1:0]          key_q;
  logic [SAMPLE_W-1:0]       smp_q;
  logic [TIME_W-1:0]         now_q;
  logic signed [BOUND_W-1:0] blo_q;
  logic signed [BOUND_W-1:0] bhi_q;

  // working registers
  logic [SAMPLE_W-1:0]       smp_r;
  logic signed [BOUND_W-1:0] lo_r;
  logic signed [BOUND_W-1:0] hi_r;
  logic [TIME_W-1:0]         last_r;
  logic [SAMPLE_W-1:0]       prev_r;
  logic [REM_W-1:0]          rem_r;
  logic [REM_W-1:0]          ad_r;
  logic [LEVEL_W-1:0]        level_r;

  // memory port
  logic               accept;
  logic               ram_we;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             ent;
  entry_t             ent_wr;

  // datapath wires
  logic [NUM_KEYS-1:0]       key_bit;
  logic                      in_range;
  logic                      is_sample;
  logic [SAMPLE_W-1:0]       smp_clamp;
  logic [SAMPLE_W-1:0]       smp_cond;
  logic signed [WIDE_W-1:0]  raw_w;
  logic signed [WIDE_W-1:0]  ent_lo_w;
  logic signed [WIDE_W-1:0]  ent_hi_w;
  logic signed [BOUND_W-1:0] lo_calc;
  logic signed [BOUND_W-1:0] hi_calc;
  logic signed [WIDE_W-1:0]  num_w;
  logic signed [WIDE_W-1:0]  den_w;
  logic [WIDE_W-1:0]         an_w;
  logic [WIDE_W-1:0]         ad_w;
  logic                      level_zero;
  logic                      level_sat;
  logic [REM_W:0]            div_t;
  logic                      div_ge;
  logic [TIME_W-1:0]         elapsed;
  logic                      on_next;
  logic [TIME_W-1:0]         time_next;
  logic                      rchg;
  logic                      pchg;
  logic                      proceed;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign ram_re    = accept && (key_index < KEY_W'(NUM_KEYS));

  assign key_bit   = NUM_KEYS'(1) << key_q;
  assign in_range  = (key_q < KEY_W'(NUM_KEYS));
  assign is_sample = in_range && (func_q == FUNC_SAMPLE);
  assign proceed   = !out_valid || !out_stall;

  ksc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_KEYS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (key_q[ADDR_W-1:0]),
    .wdata (ent_wr),
    .re    (ram_re),
    .raddr (key_index[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // entry read, with never written keys at their default bounds
  assign ent = (|(key_valid & key_bit)) ? entry_t'(ram_rdata) : ENTRY_RESET;

  // sample conditioning, bound loading and bound tracking
  always_comb begin
    smp_clamp = (smp_q > SAMPLE_W'(SAMPLE_MAX)) ? SAMPLE_W'(SAMPLE_MAX) : smp_q;
    smp_cond  = (|(invert_mask & key_bit)) ? SAMPLE_W'(SAMPLE_MAX) - smp_clamp : smp_clamp;
    raw_w     = $signed({{(WIDE_W - SAMPLE_W){1'b0}}, smp_cond});
    ent_lo_w  = WIDE_W'(ent.lower);
    ent_hi_w  = WIDE_W'(ent.upper);
    lo_calc   = ent.lower;
    hi_calc   = ent.upper;
    if (func_q == FUNC_LOAD) begin
      lo_calc = blo_q;
      hi_calc = bhi_q;
    end else if (|(calibrate_mask & key_bit)) begin
      if (raw_w < ent_lo_w) begin
        lo_calc = sat_bound($signed(WIDE_W'(raw_w + WIDE_W'(CAL_MARGIN))));
      end
      if (raw_w > ent_hi_w) begin
        hi_calc = sat_bound($signed(WIDE_W'(raw_w - WIDE_W'(CAL_MARGIN))));
      end
    end
  end

  // quotient setup
  always_comb begin
    num_w      = $signed({{(WIDE_W - SAMPLE_W){1'b0}}, smp_r}) - WIDE_W'(lo_r);
    den_w      = WIDE_W'(hi_r) - WIDE_W'(lo_r);
    an_w       = num_w[WIDE_W-1] ? WIDE_W'(-num_w) : WIDE_W'(num_w);
    ad_w       = den_w[WIDE_W-1] ? WIDE_W'(-den_w) : WIDE_W'(den_w);
    level_zero = (num_w == '0) || (den_w == '0) || (num_w[WIDE_W-1] != den_w[WIDE_W-1]);
    level_sat  = (an_w >= ad_w);
  end

  // one quotient bit per cycle
  assign div_t  = {rem_r, 1'b0};
  assign div_ge = (div_t >= {1'b0, ad_r});

  // hysteresis, debounce and change reporting
  always_comb begin
    elapsed            = now_q - last_r;
    on_next            = |(pressed_bits & key_bit);
    time_next          = last_r;
    rchg               = 1'b0;
    pchg               = 1'b0;
    pressed_bits_next  = pressed_bits;
    reported_bits_next = reported_bits;
    if (is_sample) begin
      if (level_r < release_threshold) begin
        on_next = 1'b0;
      end else if (level_r > press_threshold) begin
        if (elapsed > TIME_W'(debounce_ms)) begin
          on_next   = 1'b1;
          time_next = now_q;
        end
      end
      pressed_bits_next = on_next ? (pressed_bits | key_bit) : (pressed_bits & ~key_bit);
      if (smp_r != prev_r) begin
        rchg = 1'b1;
        if ((|(reported_bits & key_bit)) != on_next) begin
          pchg = 1'b1;
          reported_bits_next = on_next ? (reported_bits | key_bit) :
                                         (reported_bits & ~key_bit);
        end
      end
    end
    ent_wr.lower     = lo_r;
    ent_wr.upper     = hi_r;
    ent_wr.last_time = time_next;
    ent_wr.prev      = is_sample ? smp_r : prev_r;
  end

  // next state
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        state_next = is_sample ? ST_PREP : ST_DECIDE;
      end
      ST_PREP: begin
        state_next = (level_zero || level_sat) ? ST_DECIDE : ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(LEVEL_W - 1)) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (proceed) begin
          ram_we     = in_range;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      calibrate_mask    <= '0;
      invert_mask       <= '0;
      press_threshold   <= PRESS_TH_RESET;
      release_threshold <= RELEASE_TH_RESET;
      debounce_ms       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CALIBRATE:  calibrate_mask    <= cfg_data[NUM_KEYS-1:0];
        CFG_INVERT:     invert_mask       <= cfg_data[NUM_KEYS-1:0];
        CFG_PRESS_TH:   press_threshold   <= cfg_data[LEVEL_W-1:0];
        CFG_RELEASE_TH: release_threshold <= cfg_data[LEVEL_W-1:0];
        CFG_DEBOUNCE:   debounce_ms       <= cfg_data[DEB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // key state bits
  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid     <= '0;
      pressed_bits  <= '0;
      reported_bits <= '0;
    end else if (state == ST_DECIDE && proceed) begin
      key_valid     <= key_valid | key_bit;
      pressed_bits  <= pressed_bits_next;
      reported_bits <= reported_bits_next;
    end
  end

  // item capture and datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func;
      key_q  <= key_index;
      smp_q  <= sample;
      now_q  <= time_ms;
      blo_q  <= bound_low;
      bhi_q  <= bound_high;
    end
    case (state)
      ST_CALC: begin
        smp_r   <= smp_cond;
        lo_r    <= lo_calc;
        hi_r    <= hi_calc;
        last_r  <= ent.last_time;
        prev_r  <= ent.prev;
        level_r <= '0;
      end
      ST_PREP: begin
        rem_r   <= an_w[REM_W-1:0];
        ad_r    <= ad_w[REM_W-1:0];
        div_cnt <= '0;
        level_r <= (!level_zero && level_sat) ? '1 : '0;
      end
      ST_DIV: begin
        rem_r   <= div_ge ? REM_W'(div_t - {1'b0, ad_r}) : div_t[REM_W-1:0];
        level_r <= {level_r[LEVEL_W-2:0], div_ge};
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DECIDE && proceed) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DECIDE && proceed) begin
      out_key       <= key_q;
      level         <= is_sample ? level_r : '0;
      pressed       <= |(pressed_bits_next & key_bit);
      press_changed <= pchg;
      raw_changed   <= rchg;
      press_bitmap  <= pressed_bits_next;
    end
  end

endmodule

// File: src/ksc_checker.sv
// ----------------------------------------------------------------------------
// ksc_checker
// Port-level checks of the key sensor conditioner, bound to the top level.
// ----------------------------------------------------------------------------
module ksc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [ksc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input logic [ksc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                func,
  input logic [ksc_pkg::KEY_W-1:0]           key_index,
  input logic [ksc_pkg::SAMPLE_W-1:0]        sample,
  input logic [ksc_pkg::TIME_W-1:0]          time_ms,
  input logic signed [ksc_pkg::BOUND_W-1:0]  bound_low,
  input logic signed [ksc_pkg::BOUND_W-1:0]  bound_high,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [ksc_pkg::KEY_W-1:0]           out_key,
  input logic [ksc_pkg::LEVEL_W-1:0]         level,
  input logic                                pressed,
  input logic                                press_changed,
  input logic                                raw_changed,
  input logic [ksc_pkg::NUM_KEYS-1:0]        press_bitmap
);

  import ksc_pkg::*;

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_key) && $stable(level)))
    else $error("stalled result changed");

  a_bitmap_match: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_key < KEY_W'(NUM_KEYS)) |-> (pressed == press_bitmap[out_key]))
    else $error("pressed disagrees with bitmap");

  a_unknown_key: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_key >= KEY_W'(NUM_KEYS)) |->
      (level == '0 && !pressed && !press_changed && !raw_changed))
    else $error("unknown key gave a nonzero result");

  a_change_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && press_changed) |-> raw_changed)
    else $error("press change reported without a sample change");

endmodule

bind key_sensor_conditioner_top ksc_checker u_ksc_checker (.*);

// File: tb/tb_key_sensor_conditioner_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_sensor_conditioner_top
// Self-checking bench for the key sensor conditioner. A short directed table
// hits bound extremes, equal and reversed bounds, unknown keys, inversion,
// calibration and threshold extremes. Random phases with different register
// settings and handshake idling follow. Every result transfer is compared
// field by field to a typed row's expectation or a behavioral per-key model.
// ----------------------------------------------------------------------------
module tb_key_sensor_conditioner_top;
  import ksc_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [LEVEL_W-1:0]  level;
    logic                pressed;
    logic                press_changed;
    logic                raw_changed;
    logic [NUM_KEYS-1:0] bitmap;
  } key_report_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic                       func;
    logic [KEY_W-1:0]           key;
    logic [SAMPLE_W-1:0]        smp;
    logic [TIME_W-1:0]          tms;
    logic signed [BOUND_W-1:0]  blo;
    logic signed [BOUND_W-1:0]  bhi;
    cfg_idx_t                   reg_idx;
    logic [CFG_DATA_W-1:0]      reg_val;
    bit                         typed;
    key_report_t                want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = 1'b0;
  logic [KEY_W-1:0] key_index = '0;
  logic [SAMPLE_W-1:0] sample = '0;
  logic [TIME_W-1:0] time_ms = '0;
  logic signed [BOUND_W-1:0] bound_low = '0;
  logic signed [BOUND_W-1:0] bound_high = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [KEY_W-1:0] out_key;
  logic [LEVEL_W-1:0] level;
  logic pressed;
  logic press_changed;
  logic raw_changed;
  logic [NUM_KEYS-1:0] press_bitmap;

  key_sensor_conditioner_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .key_index(key_index), .sample(sample), .time_ms(time_ms),
    .bound_low(bound_low), .bound_high(bound_high),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_key(out_key), .level(level), .pressed(pressed),
    .press_changed(press_changed), .raw_changed(raw_changed),
    .press_bitmap(press_bitmap)
  );

  always #5 clk = ~clk;

  // model copy of registers and per-key state
  logic [NUM_KEYS-1:0] cal_mask, inv_mask;
  logic [LEVEL_W-1:0]  press_th, release_th;
  logic [DEB_W-1:0]    debounce;
  int                  lo_bound [NUM_KEYS];
  int                  hi_bound [NUM_KEYS];
  logic [TIME_W-1:0]   last_press [NUM_KEYS];
  int                  prev_raw [NUM_KEYS];
  logic [NUM_KEYS-1:0] press_bits, report_bits;

  key_report_t         key_report_q [$];
  int                  error_count = 0;
  int unsigned         src_idle_pct = 0;
  int unsigned         sink_stall_pct = 0;
  logic [TIME_W-1:0]   clock_ms = '0;
  logic [SAMPLE_W-1:0] last_sent [32];
  stim_row_t           dir_rows [25];

  function automatic key_report_t condition_item(
      input logic fn, input logic [KEY_W-1:0] k, input logic [SAMPLE_W-1:0] s,
      input logic [TIME_W-1:0] t, input logic signed [BOUND_W-1:0] blo,
      input logic signed [BOUND_W-1:0] bhi);
    key_report_t         r;
    logic [NUM_KEYS-1:0] kbit;
    logic                on;
    int                  raw, num, den;
    logic [63:0]         q;
    logic [LEVEL_W-1:0]  lvl;
    r = '0;
    r.key = k;
    if (k < NUM_KEYS) begin
      kbit = NUM_KEYS'(1) << k;
      if (fn == FUNC_LOAD) begin
        lo_bound[k] = int'(blo);
        hi_bound[k] = int'(bhi);
      end else begin
        on = (press_bits & kbit) != 0;
        raw = (inv_mask & kbit) != 0 ? SAMPLE_MAX - int'(s) : int'(s);
        if ((cal_mask & kbit) != 0) begin
          if (raw < lo_bound[k]) lo_bound[k] = raw + CAL_MARGIN;
          if (raw > hi_bound[k]) hi_bound[k] = raw - CAL_MARGIN;
        end
        num = raw - lo_bound[k];
        den = hi_bound[k] - lo_bound[k];
        if (den == 0 || num == 0 || ((num < 0) != (den < 0))) begin
          lvl = '0;
        end else begin
          q = (64'(num < 0 ? -num : num) << 16) / 64'(den < 0 ? -den : den);
          lvl = q > 64'hFFFF ? 16'hFFFF : q[15:0];
        end
        if (lvl < release_th) begin
          on = 1'b0;
        end else if (lvl > press_th && (t - last_press[k]) > TIME_W'(debounce)) begin
          on = 1'b1;
          last_press[k] = t;
        end
        press_bits = on ? (press_bits | kbit) : (press_bits & ~kbit);
        if (raw != prev_raw[k]) begin
          r.raw_changed = 1'b1;
          if (((report_bits & kbit) != 0) != on) begin
            r.press_changed = 1'b1;
            report_bits = on ? (report_bits | kbit) : (report_bits & ~kbit);
          end
          prev_raw[k] = raw;
        end
        r.level = lvl;
      end
      r.pressed = (press_bits & kbit) != 0;
    end
    r.bitmap = press_bits;
    return r;
  endfunction

  task automatic send_item(
      input logic fn, input logic [KEY_W-1:0] k, input logic [SAMPLE_W-1:0] s,
      input logic [TIME_W-1:0] t, input logic signed [BOUND_W-1:0] blo,
      input logic signed [BOUND_W-1:0] bhi, input bit typed, input key_report_t want);
    key_report_t pred;
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    in_valid   <= 1'b1;
    func       <= fn;
    key_index  <= k;
    sample     <= s;
    time_ms    <= t;
    bound_low  <= blo;
    bound_high <= bhi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = condition_item(fn, k, s, t, blo, bhi);
    key_report_q.push_back(typed ? want : pred);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (key_report_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_CALIBRATE:  cal_mask = val;
      CFG_INVERT:     inv_mask = val;
      CFG_PRESS_TH:   press_th = val[LEVEL_W-1:0];
      CFG_RELEASE_TH: release_th = val[LEVEL_W-1:0];
      CFG_DEBOUNCE:   debounce = val[DEB_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item();
    logic                      fn;
    logic [KEY_W-1:0]          k;
    logic [SAMPLE_W-1:0]       s;
    logic signed [BOUND_W-1:0] blo, bhi;
    int unsigned               pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) k = KEY_W'($urandom_range(NUM_KEYS, 31));
    else if (pick < 60) k = KEY_W'($urandom_range(0, 2));
    else k = KEY_W'($urandom_range(0, NUM_KEYS - 1));
    fn = ($urandom_range(0, 99) < 10) ? FUNC_LOAD : FUNC_SAMPLE;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      blo = BOUND_W'($urandom_range(0, 400));
      bhi = BOUND_W'($urandom_range(600, SAMPLE_MAX));
    end else if (pick < 80) begin
      blo = BOUND_W'($urandom);
      bhi = blo;
    end else begin
      blo = BOUND_W'($urandom);
      bhi = BOUND_W'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 25) s = last_sent[k];
    else if (pick < 60) s = SAMPLE_W'($urandom_range(800, SAMPLE_MAX));
    else if (pick < 90) s = SAMPLE_W'($urandom_range(0, 200));
    else s = SAMPLE_W'($urandom);
    if (fn == FUNC_SAMPLE) last_sent[k] = s;
    if ($urandom_range(0, 99) < 2) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 8);
    send_item(fn, k, s, clock_ms, blo, bhi, 1'b0, '0);
  endtask

  always @(posedge clk) begin : check_reports
    key_report_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{out_key, level, pressed, press_changed, raw_changed, press_bitmap};
      if (key_report_q.size() == 0) begin
        $display("%0t unexpected transfer: key %0d level %0d", $time, out_key, level);
        error_count++;
      end else begin
        want = key_report_q.pop_front();
        if (got.key !== want.key) begin
          $display("%0t out_key expected %0d actual %0d", $time, want.key, got.key);
          error_count++;
        end
        if (got.level !== want.level) begin
          $display("%0t level expected %0d actual %0d", $time, want.level, got.level);
          error_count++;
        end
        if (got.pressed !== want.pressed) begin
          $display("%0t pressed expected %0b actual %0b", $time, want.pressed, got.pressed);
          error_count++;
        end
        if (got.press_changed !== want.press_changed) begin
          $display("%0t press_changed expected %0b actual %0b", $time,
                   want.press_changed, got.press_changed);
          error_count++;
        end
        if (got.raw_changed !== want.raw_changed) begin
          $display("%0t raw_changed expected %0b actual %0b", $time,
                   want.raw_changed, got.raw_changed);
          error_count++;
        end
        if (got.bitmap !== want.bitmap) begin
          $display("%0t press_bitmap expected %h actual %h", $time, want.bitmap, got.bitmap);
          error_count++;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  initial begin
    #10_000_000;
    $display("tb_key_sensor_conditioner_top failed");
    $finish;
  end

  initial begin
    int unsigned         idle_tab [4];
    int unsigned         stall_tab [4];
    logic [NUM_KEYS-1:0] cal_v, inv_v;
    logic [LEVEL_W-1:0]  pth_v, rth_v;
    logic [DEB_W-1:0]    deb_v;
    idle_tab  = '{0, 48, 0, 11};
    stall_tab = '{0, 0, 48, 11};
    cal_mask = '0;
    inv_mask = '0;
    press_th = PRESS_TH_RESET;
    release_th = RELEASE_TH_RESET;
    debounce = '0;
    press_bits = '0;
    report_bits = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      lo_bound[i] = 0;
      hi_bound[i] = SAMPLE_MAX;
      last_press[i] = '0;
      prev_raw[i] = 0;
    end
    foreach (last_sent[i]) last_sent[i] = '0;

    // kind func key sample time low high reg value typed expected
    dir_rows = '{
      '{ROW_ITEM, FUNC_SAMPLE, 5'd0, 10'd0, 32'd0, 12'sd0, 12'sd0, CFG_CALIBRATE, 25'd0,
        1'b1, '{5'd0, 16'd0, 1'b0, 1'b0, 1'b0, 25'h0}},
      '{ROW_ITEM, FUNC_SAMPLE, 5'd0, 10'd1023, 32'd5, 12'sd0, 12'sd0, CFG_CALIBRATE, 25'd0,
        1'b1, '{5'd0, 16'hFFFF, 1'b1, 1'b1, 1'b1, 25'h1}},
      '{ROW_ITEM, FUNC_SAMPLE, 5'd24, 10'd1023, 32'd6, 12'sd0, 12'sd0, CFG_CALIBRATE, 25'd0,
        1'b1, '{5'd24, 16'hFFFF, 1'b1, 1'b1, 1'b1, 25'h1000001}},
      '{ROW_ITEM, FUNC_SAMPLE, 5'd0, 10'd1023, 32'd5, 12'sd0, 12'sd0, CFG_CALIBRATE, 25'd0,
        1'b1, '{5'd0, 16'hFFFF, 1'b1, 1'b0, 1'b0, 25'h1000001}},
      '{ROW_ITEM, FUNC_SAMPLE, 5'd0, 10'd0, 32'd7, 12'sd0, 12'sd0, CFG_CALIBRATE, 25'd0,
        1'b1, '{5'd0, 16'd0, 1'b0, 1'b1, 1'b1, 25'h1000000}},
      '{ROW_ITEM, FUNC_SAMPLE, 5'd31, 10'd512, 32'd8, 12'sd0, 12'sd0, CFG_CALIBRATE, 25'd0,
        1'b1, '{5'd31, 16'd0, 1'b0, 1'b0, 1'b0, 25'h1000000}},
      '{ROW_ITEM, FUNC_LOAD, 5'd25, 10'd0, 32'd8, 12'hFFF, 12'sd5, CFG_CALIBRATE, 25'd0,
        1'b1, '{5'd25, 16'd0, 1'b0, 1'b0, 1'b0, 25'h1000000}},
      '{ROW_ITEM, FUNC_LOAD, 5'd3, 10'd0, 32'd8, 12'sd100, 12'sd100, CFG_CALIBRATE, 25'd0,
        1'b1, '{5'd3, 16'd0, 1'b0, 1'b0, 1'b0, 25'h1000000}},
      '{ROW_ITEM, FUNC_SAMPLE, 5'd3, 10'd500, 32'd9, 12'sd0, 12'sd0, CFG_CALIBRATE, 25'd0,
        1'b1, '{5'd3, 16'd0, 1'b0, 1'b0, 1'b1, 25'h1000000}},
      '{ROW_ITEM, FUNC_LOAD, 5'd4, 10'd0, 32'd9, 12'h7FF, 12'h800, CFG_CALIBRATE, 25'd0,
        1'b1, '{5'd4, 16'd0, 1'b0, 1'b0, 1'b0, 25'h1000000}},
      '{ROW_ITEM, FUNC_SAMPLE, 5'd4, 10'd0, 32'd10, 12'sd0, 12'sd0, CFG_CALIBRATE, 25'd0,
        1'b0, '0},
      '{ROW_ITEM, FUNC_LOAD, 5'd5, 10'd0, 32'd10, 12'sd1000, 12'sd0, CFG_CALIBRATE, 25'd0,
        1'b0, '0},
      '{ROW_ITEM, FUNC_SAMPLE, 5'd5, 10'd0, 32'd20, 12'sd0, 12'sd0, CFG_CALIBRATE, 25'd0,
        1'b0, '0},
      '{ROW_ITEM, FUNC_SAMPLE, 5'd5, 10'd1023, 32'd21, 12'sd0, 12'sd0, CFG_CALIBRATE, 25'd0,
        1'b0, '0},
      '{ROW_REG, FUNC_SAMPLE, 5'd0, 10'd0, 32'd0, 12'sd0, 12'sd0, CFG_INVERT, 25'h1FFFFFF,
        1'b0, '0},
      '{ROW_ITEM, FUNC_SAMPLE, 5'd6, 10'd0, 32'd30, 12'sd0, 12'sd0, CFG_CALIBRATE, 25'd0,
        1'b0, '0},
      '{ROW_REG, FUNC_SAMPLE, 5'd0, 10'd0, 32'd0, 12'sd0, 12'sd0, CFG_CALIBRATE, 25'h1FFFFFF,
        1'b0, '0},
      '{ROW_ITEM, FUNC_LOAD, 5'd7, 10'd0, 32'd30, 12'sd500, 12'sd600, CFG_CALIBRATE, 25'd0,
        1'b0, '0},
      '{ROW_ITEM, FUNC_SAMPLE, 5'd7, 10'd100, 32'd40, 12'sd0, 12'sd0, CFG_CALIBRATE, 25'd0,
        1'b0, '0},
      '{ROW_ITEM, FUNC_SAMPLE, 5'd7, 10'd1023, 32'd41, 12'sd0, 12'sd0, CFG_CALIBRATE, 25'd0,
        1'b0, '0},
      '{ROW_REG, FUNC_SAMPLE, 5'd0, 10'd0, 32'd0, 12'sd0, 12'sd0, CFG_PRESS_TH, 25'd65535,
        1'b0, '0},
      '{ROW_REG, FUNC_SAMPLE, 5'd0, 10'd0, 32'd0, 12'sd0, 12'sd0, CFG_RELEASE_TH, 25'd0,
        1'b0, '0},
      '{ROW_REG, FUNC_SAMPLE, 5'd0, 10'd0, 32'd0, 12'sd0, 12'sd0, CFG_DEBOUNCE, 25'd65535,
        1'b0, '0},
      '{ROW_ITEM, FUNC_SAMPLE, 5'd8, 10'd0, 32'd50, 12'sd0, 12'sd0, CFG_CALIBRATE, 25'd0,
        1'b0, '0},
      '{ROW_ITEM, FUNC_SAMPLE, 5'd8, 10'd1023, 32'd60, 12'sd0, 12'sd0, CFG_CALIBRATE, 25'd0,
        1'b0, '0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        wait_quiet();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_item(dir_rows[i].func, dir_rows[i].key, dir_rows[i].smp, dir_rows[i].tms,
                  dir_rows[i].blo, dir_rows[i].bhi, dir_rows[i].typed, dir_rows[i].want);
      end
    end
    clock_ms = 100;

    for (int ph = 0; ph < 4; ph++) begin
      wait_quiet();
      case (ph)
        0: begin
          cal_v = '0; inv_v = '0; pth_v = LEVEL_W'(40000); rth_v = LEVEL_W'(20000);
          deb_v = '0;
        end
        1: begin
          cal_v = '1; inv_v = NUM_KEYS'($urandom);
          pth_v = LEVEL_W'($urandom_range(30000, 50000));
          rth_v = LEVEL_W'($urandom_range(8000, 30000));
          deb_v = DEB_W'($urandom_range(1, 40));
        end
        2: begin
          cal_v = NUM_KEYS'($urandom); inv_v = '1; pth_v = '0; rth_v = '1; deb_v = '1;
        end
        default: begin
          cal_v = NUM_KEYS'($urandom); inv_v = NUM_KEYS'($urandom);
          pth_v = LEVEL_W'($urandom); rth_v = LEVEL_W'($urandom);
          deb_v = DEB_W'($urandom_range(0, 25));
        end
      endcase
      write_reg(CFG_CALIBRATE, cal_v);
      write_reg(CFG_INVERT, inv_v);
      write_reg(CFG_PRESS_TH, CFG_DATA_W'(pth_v));
      write_reg(CFG_RELEASE_TH, CFG_DATA_W'(rth_v));
      write_reg(CFG_DEBOUNCE, CFG_DATA_W'(deb_v));
      src_idle_pct = idle_tab[ph];
      sink_stall_pct = stall_tab[ph];
      for (int n = 0; n < 320; n++) begin
        // hold off new items until every pending result is back
        if (n == 160) wait_quiet();
        random_item();
      end
    end
    wait_quiet();

    if (error_count == 0) begin
      $display("tb_key_sensor_conditioner_top passed");
    end else begin
      $display("tb_key_sensor_conditioner_top failed");
    end
    $finish;
  end

endmodule

// File: key_sensor_conditioner_top.f
src/ksc_pkg.sv
src/ksc_ram.sv
src/key_sensor_conditioner_top.sv
src/ksc_checker.sv
tb/tb_key_sensor_conditioner_top.sv
